/* design/mpr_pkg.sv */
package mpr_pkg;

	localparam int DATA_W  = 8;
	localparam int LIMIT_W = 3;
	localparam int POS_W   = 9;
	localparam int ARGS_W  = 8;
	localparam int STATE_W = 3;

	// queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DATA_W;

	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT   = 1'b1;

	localparam logic [DATA_W-1:0]  START_ADDRESS_RST = 8'd1;
	localparam logic [LIMIT_W-1:0] ERROR_LIMIT_RST   = 3'd5;

	typedef enum logic [STATE_W-1:0] {
		PH_IDLE    = 3'd0,
		PH_SENDER  = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_COMMAND = 3'd3,
		PH_ARGS    = 3'd4,
		PH_ERROR   = 3'd5
	} phase_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              mark;
	} rx_item_t;

	typedef struct packed {
		logic [DATA_W-1:0]  start_address;
		logic [LIMIT_W-1:0] error_limit;
	} cfg_t;

	function automatic logic odd_parity(input logic [DATA_W-1:0] b);
		odd_parity = ^b;
	endfunction

endpackage

/* design/mpr_if.sv */
interface mpr_in_if;
	logic                      valid;
	logic                      ready;
	logic [mpr_pkg::DATA_W-1:0] rx_data;
	logic                      parity_error;

	modport source (output valid, output rx_data, output parity_error, input ready);
	modport sink   (input valid, input rx_data, input parity_error, output ready);
endinterface

interface mpr_out_if;
	logic                        valid;
	logic                        ready;
	logic                        byte_valid;
	logic [mpr_pkg::DATA_W-1:0]  stored_byte;
	logic [mpr_pkg::POS_W-1:0]   byte_index;
	logic                        frame_done;
	logic [mpr_pkg::STATE_W-1:0] frame_state;
	logic [mpr_pkg::LIMIT_W-1:0] error_level;
	logic                        gave_up;

	modport source (output valid, output byte_valid, output stored_byte, output byte_index,
		output frame_done, output frame_state, output error_level, output gave_up,
		input ready);
	modport sink (input valid, input byte_valid, input stored_byte, input byte_index,
		input frame_done, input frame_state, input error_level, input gave_up,
		output ready);
endinterface

/* design/mpr_front.sv */
module mpr_front (
	mpr_in_if.sink              rx,
	input  logic                full,
	output logic                push,
	output mpr_pkg::rx_item_t   item
);

	// ninth bit recovered: parity disagreeing with the error flag marks an address
	assign item.data = rx.rx_data;
	assign item.mark = mpr_pkg::odd_parity(rx.rx_data) ^ rx.parity_error;

	assign rx.ready = !full;
	assign push     = rx.valid && !full;

endmodule

/* design/mpr_queue.sv */
module mpr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mpr_pkg::rx_item_t wr_item,
	input  logic              pop,
	output mpr_pkg::rx_item_t rd_item,
	output logic              full,
	output logic              empty
);

	mpr_pkg::rx_item_t                 entry_q [mpr_pkg::QDEPTH];
	logic [mpr_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [mpr_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [mpr_pkg::QCNT_W-1:0]        count_q;

	localparam logic [mpr_pkg::QCNT_W-1:0] QFULL   = mpr_pkg::QCNT_W'(mpr_pkg::QDEPTH);
	localparam logic [mpr_pkg::QPTR_W-1:0] PTR_MAX = mpr_pkg::QPTR_W'(mpr_pkg::QDEPTH - 1);

	assign full    = (count_q == QFULL);
	assign empty   = (count_q == '0);
	assign rd_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/mpr_back.sv */
module mpr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mpr_pkg::cfg_t     cfg,
	input  logic              empty,
	input  mpr_pkg::rx_item_t item,
	output logic              pop,
	mpr_out_if.source         res
);

	mpr_pkg::phase_t                 phase_q, phase_d;
	logic [mpr_pkg::ARGS_W-1:0]      args_q, args_d;
	logic [mpr_pkg::POS_W-1:0]       pos_q, pos_d;
	logic [mpr_pkg::LIMIT_W-1:0]     bad_q, bad_d;

	logic                            valid_q;
	logic                            bvalid_q, done_q, gave_q;
	logic [mpr_pkg::DATA_W-1:0]      sbyte_q;
	logic [mpr_pkg::POS_W-1:0]       index_q;
	logic [mpr_pkg::STATE_W-1:0]     fstate_q;
	logic [mpr_pkg::LIMIT_W-1:0]     level_q;

	logic                            is_start, limit_hit, last_byte, mid_frame;
	logic [mpr_pkg::ARGS_W-1:0]      args_dec;
	logic [mpr_pkg::LIMIT_W-1:0]     bad_inc;
	logic                            bvalid_d, done_d, gave_d;
	logic [mpr_pkg::POS_W-1:0]       index_d;

	assign pop = !empty && (!valid_q || res.ready);

	assign is_start  = item.mark && (item.data == cfg.start_address);
	assign bad_inc   = bad_q + 1'b1;
	assign limit_hit = (bad_inc >= cfg.error_limit);
	assign args_dec  = args_q - 1'b1;
	assign mid_frame = (phase_q == mpr_pkg::PH_SENDER) || (phase_q == mpr_pkg::PH_LENGTH)
		|| (phase_q == mpr_pkg::PH_COMMAND) || (phase_q == mpr_pkg::PH_ARGS);
	assign last_byte = ((phase_q == mpr_pkg::PH_COMMAND) && (args_q == '0))
		|| ((phase_q == mpr_pkg::PH_ARGS) && (args_dec == '0));

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			mpr_pkg::PH_SENDER: begin
				phase_d = item.mark ? mpr_pkg::PH_ERROR : mpr_pkg::PH_LENGTH;
			end
			mpr_pkg::PH_LENGTH: begin
				phase_d = item.mark ? mpr_pkg::PH_ERROR : mpr_pkg::PH_COMMAND;
			end
			mpr_pkg::PH_COMMAND, mpr_pkg::PH_ARGS: begin
				if (item.mark) begin
					phase_d = mpr_pkg::PH_ERROR;
				end else if (last_byte) begin
					phase_d = mpr_pkg::PH_IDLE;
				end else begin
					phase_d = mpr_pkg::PH_ARGS;
				end
			end
			mpr_pkg::PH_ERROR: begin
				if (is_start) begin
					phase_d = mpr_pkg::PH_SENDER;
				end else if (item.mark && limit_hit) begin
					phase_d = mpr_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = is_start ? mpr_pkg::PH_SENDER : mpr_pkg::PH_IDLE;
			end
		endcase
	end

	// frame counters and result fields
	always_comb begin
		args_d   = args_q;
		pos_d    = pos_q;
		bad_d    = bad_q;
		bvalid_d = 1'b0;
		index_d  = '0;
		done_d   = 1'b0;
		gave_d   = 1'b0;
		if (mid_frame) begin
			if (item.mark) begin
				args_d = '0;
				pos_d  = '0;
				bad_d  = '0;
			end else begin
				bvalid_d = 1'b1;
				index_d  = pos_q;
				pos_d    = pos_q + 1'b1;
				if (phase_q == mpr_pkg::PH_LENGTH) begin
					args_d = item.data;
				end else if (phase_q == mpr_pkg::PH_ARGS) begin
					args_d = args_dec;
				end
				if (last_byte) begin
					done_d = 1'b1;
					args_d = '0;
					pos_d  = '0;
					bad_d  = '0;
				end
			end
		end else begin
			if (phase_q != mpr_pkg::PH_ERROR) begin
				// idle, or a code outside the phase list: start from a clear frame
				args_d = '0;
				pos_d  = '0;
				bad_d  = '0;
			end
			if (is_start) begin
				bvalid_d = 1'b1;
				pos_d    = mpr_pkg::POS_W'(1);
				bad_d    = '0;
				args_d   = '0;
			end else if (item.mark && (phase_q == mpr_pkg::PH_ERROR)) begin
				if (limit_hit) begin
					gave_d = 1'b1;
					args_d = '0;
					pos_d  = '0;
					bad_d  = '0;
				end else begin
					bad_d = bad_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mpr_pkg::PH_IDLE;
			args_q  <= '0;
			pos_q   <= '0;
			bad_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				args_q  <= args_d;
				pos_q   <= pos_d;
				bad_q   <= bad_d;
			end
			if (pop) begin
				valid_q <= 1'b1;
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bvalid_q <= bvalid_d;
			sbyte_q  <= bvalid_d ? item.data : '0;
			index_q  <= index_d;
			done_q   <= done_d;
			gave_q   <= gave_d;
			fstate_q <= phase_d;
			level_q  <= bad_d;
		end
	end

	assign res.valid       = valid_q;
	assign res.byte_valid  = bvalid_q;
	assign res.stored_byte = sbyte_q;
	assign res.byte_index  = index_q;
	assign res.frame_done  = done_q;
	assign res.frame_state = fstate_q;
	assign res.error_level = level_q;
	assign res.gave_up     = gave_q;

endmodule

/* design/multidrop_packet_receiver_top.sv */
// Multidrop packet receiver with a ninth-bit address mark.
// rx carries one received UART byte and its parity-error flag per transaction;
// res returns exactly one result per byte: whether it was stored, its index in
// the frame, end of frame, the frame phase, the error count and a give-up flag.
// Configuration: cfg_we with cfg_idx 0 writes start_address, 1 writes
// error_limit; write only while no transaction is in flight.
// A front stage recovers the address mark and pushes into a two-entry queue;
// the back stage runs the frame sequencer and loads a result register.
// With res free, the queue takes each rx byte and the back stage then pops it
// into the result register.
// Throughput: one byte per cycle while res is ready.
// When res stalls, the result register holds, the queue fills and rx.ready
// drops once both entries are taken; nothing is lost.
// Reset: the queue empties, the sequencer returns to idle with cleared
// counters, and the registers take start_address 1 and error_limit 5.
module multidrop_packet_receiver_top (
	input  logic                               clk,
	input  logic                               arst_n,
	mpr_in_if.sink                             rx,
	mpr_out_if.source                          res,
	input  logic                               cfg_we,
	input  logic [mpr_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [mpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	mpr_pkg::cfg_t     cfg_q;
	mpr_pkg::rx_item_t wr_item, rd_item;
	logic              push, pop, full, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_address <= mpr_pkg::START_ADDRESS_RST;
			cfg_q.error_limit   <= mpr_pkg::ERROR_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				mpr_pkg::CFG_START_ADDRESS: cfg_q.start_address <= cfg_data;
				mpr_pkg::CFG_ERROR_LIMIT:
					cfg_q.error_limit <= cfg_data[mpr_pkg::LIMIT_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	mpr_front u_front (
		.rx   (rx),
		.full (full),
		.push (push),
		.item (wr_item)
	);

	mpr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.full    (full),
		.empty   (empty)
	);

	mpr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.empty  (empty),
		.item   (rd_item),
		.pop    (pop),
		.res    (res)
	);

	a_done_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_done |-> res.byte_valid
			&& res.frame_state == mpr_pkg::PH_IDLE && res.error_level == '0)
		else $error("frame_done without a stored byte and return to idle");

	a_gave_up_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.gave_up |-> !res.byte_valid
			&& res.frame_state == mpr_pkg::PH_IDLE && res.error_level == '0)
		else $error("gave_up without return to idle");

	a_unstored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.byte_valid |-> res.stored_byte == '0 && res.byte_index == '0
			&& !res.frame_done)
		else $error("unstored byte carries payload");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> $stable(full))
		else $error("queue full flag changed without a pop");

endmodule
